>>> hw/rtl/ppu_pkg.sv
`default_nettype none

package ppu_pkg;

   // Row limit of one pattern and the width of the row counter that reaches it.
   localparam int ROWS  = 64;
   localparam int ROW_W = $clog2(ROWS + 1);

   localparam int CHAN_W     = 5;
   localparam int CHAN_CNT_W = 6;
   localparam int BYTE_W     = 8;
   localparam int MASK_W     = 3;

   localparam logic [CHAN_CNT_W-1:0] SONG_CHANNELS_RESET = 6'd32;

   // Lead byte flag positions.
   localparam int FLAG_NOTE_BIT = 5;
   localparam int FLAG_VOL_BIT  = 6;
   localparam int FLAG_EFF_BIT  = 7;

   localparam logic [BYTE_W-1:0] DEF_HI = 8'hFF;
   localparam logic [BYTE_W-1:0] DEF_LO = 8'h00;

   // Result queue between the parser and the output stage.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_LEAD  = 3'd0,
      PH_NOTE  = 3'd1,
      PH_INSTR = 3'd2,
      PH_VOL   = 3'd3,
      PH_EFF   = 3'd4,
      PH_OPER  = 3'd5
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [5:0]            row;
      logic [CHAN_W-1:0]     channel;
      logic [MASK_W-1:0]     present_mask;
      logic [BYTE_W-1:0]     note;
      logic [BYTE_W-1:0]     instrument;
      logic [BYTE_W-1:0]     volume;
      logic [BYTE_W-1:0]     effect;
      logic [BYTE_W-1:0]     effect_operand;
      logic                  pattern_done;
      logic [CHAN_CNT_W-1:0] used_channels;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type item;
   } q_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/ppu_front.sv
`default_nettype none

module ppu_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire ppu_pkg::req_payload_type            req_payload,
   input  wire logic                                csr_write,
   input  wire logic [ppu_pkg::CHAN_CNT_W-1:0]      csr_data,
   input  wire ppu_pkg::q_status_type               q_status,
   output ppu_pkg::q_push_type                      q_push
);
   import ppu_pkg::*;

   phase_type              phase_ff, phase_in, parse_phase;
   logic [BYTE_W-1:0]      flags_ff, flags_in, parse_flags;
   logic [ROW_W-1:0]       row_ff, row_in, parse_row, row_next;
   logic [CHAN_W-1:0]      hc_ff, hc_in, parse_hc, hc_eff;
   logic                   stop_ff, stop_in, parse_stop;
   logic [BYTE_W-1:0]      note_ff, note_in, instr_ff, instr_in;
   logic [BYTE_W-1:0]      vol_ff, vol_in, eff_ff, eff_in;
   logic [CHAN_CNT_W-1:0]  song_ff, song_eff, used_raw, used_clamped;
   logic [BYTE_W-1:0]      b;
   logic                   last, accept, complete, trunc, has_record;

   assign b         = req_payload.data_byte;
   assign last      = req_payload.last_byte;
   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign row_next  = row_ff + ROW_W'(1);

   // Next state: parse the byte, then fall back to a clean pattern on the last byte.
   always_comb begin
      parse_phase = phase_ff;
      parse_flags = flags_ff;
      parse_row   = row_ff;
      parse_hc    = hc_ff;
      parse_stop  = stop_ff;
      note_in     = note_ff;
      instr_in    = instr_ff;
      vol_in      = vol_ff;
      eff_in      = eff_ff;
      if (!stop_ff) begin
         case (phase_ff)
            PH_LEAD: begin
               if (b == '0) begin
                  parse_row = row_next;
                  if (row_next >= ROW_W'(ROWS)) begin
                     parse_stop = 1'b1;
                  end
               end else begin
                  parse_flags = b;
                  note_in     = DEF_HI;
                  instr_in    = DEF_LO;
                  vol_in      = DEF_HI;
                  eff_in      = DEF_HI;
                  if (b[FLAG_EFF_BIT:FLAG_NOTE_BIT] != '0) begin
                     if (b[CHAN_W-1:0] > hc_ff) begin
                        parse_hc = b[CHAN_W-1:0];
                     end
                     if (b[FLAG_NOTE_BIT]) begin
                        parse_phase = PH_NOTE;
                     end else if (b[FLAG_VOL_BIT]) begin
                        parse_phase = PH_VOL;
                     end else begin
                        parse_phase = PH_EFF;
                     end
                  end
               end
            end
            PH_NOTE: begin
               note_in     = b;
               parse_phase = PH_INSTR;
            end
            PH_INSTR: begin
               instr_in = b;
               if (flags_ff[FLAG_VOL_BIT]) begin
                  parse_phase = PH_VOL;
               end else if (flags_ff[FLAG_EFF_BIT]) begin
                  parse_phase = PH_EFF;
               end else begin
                  parse_phase = PH_LEAD;
               end
            end
            PH_VOL: begin
               vol_in      = b;
               parse_phase = flags_ff[FLAG_EFF_BIT] ? PH_EFF : PH_LEAD;
            end
            PH_EFF: begin
               eff_in      = b;
               parse_phase = PH_OPER;
            end
            PH_OPER: begin
               parse_phase = PH_LEAD;
            end
            default: begin
               parse_phase = PH_LEAD;
            end
         endcase
      end

      if (last) begin
         phase_in = PH_LEAD;
         flags_in = '0;
         row_in   = '0;
         hc_in    = CHAN_W'(1);
         stop_in  = 1'b0;
      end else begin
         phase_in = parse_phase;
         flags_in = parse_flags;
         row_in   = parse_row;
         hc_in    = parse_hc;
         stop_in  = parse_stop;
      end
   end

   // Outputs: a record finishes or is cut short, and the last byte closes the pattern.
   always_comb begin
      complete = !stop_ff && ((((phase_ff == PH_INSTR) || (phase_ff == PH_VOL))
                              && (parse_phase == PH_LEAD)) || (phase_ff == PH_OPER));
      trunc      = last && (parse_phase != PH_LEAD);
      has_record = complete || trunc;

      hc_eff       = (parse_hc == '0) ? CHAN_W'(1) : parse_hc;
      song_eff     = (song_ff == '0) ? CHAN_CNT_W'(1) : song_ff;
      used_raw     = CHAN_CNT_W'(hc_eff) + CHAN_CNT_W'(1);
      used_clamped = (used_raw > song_eff) ? song_eff : used_raw;

      q_push.valid = accept && (complete || last);
      if (has_record) begin
         q_push.item.row            = row_ff[5:0];
         q_push.item.channel        = parse_flags[CHAN_W-1:0];
         q_push.item.present_mask   = parse_flags[FLAG_EFF_BIT:FLAG_NOTE_BIT];
         q_push.item.note           = note_in;
         q_push.item.instrument     = instr_in;
         q_push.item.volume         = vol_in;
         q_push.item.effect         = eff_in;
         q_push.item.effect_operand = (complete && (phase_ff == PH_OPER)) ? b : DEF_LO;
      end else begin
         q_push.item.row            = '0;
         q_push.item.channel        = '0;
         q_push.item.present_mask   = '0;
         q_push.item.note           = '0;
         q_push.item.instrument     = '0;
         q_push.item.volume         = '0;
         q_push.item.effect         = '0;
         q_push.item.effect_operand = '0;
      end
      q_push.item.pattern_done  = last;
      q_push.item.used_channels = last ? used_clamped : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         flags_ff <= '0;
         row_ff   <= '0;
         hc_ff    <= CHAN_W'(1);
         stop_ff  <= 1'b0;
         song_ff  <= SONG_CHANNELS_RESET;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            flags_ff <= flags_in;
            row_ff   <= row_in;
            hc_ff    <= hc_in;
            stop_ff  <= stop_in;
         end
         if (csr_write) begin
            song_ff <= csr_data;
         end
      end
   end

   // Held cell bytes are always reloaded at a lead byte before use.
   always_ff @(posedge clock) begin
      if (accept) begin
         note_ff  <= note_in;
         instr_ff <= instr_in;
         vol_ff   <= vol_in;
         eff_ff   <= eff_in;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (phase_ff == PH_LEAD && row_ff == '0 && !stop_ff))
      else $error("pattern state not cleared after last byte");

   a_empty_only_done: assert property (@(posedge clock) disable iff (reset)
      (q_push.valid && q_push.item.present_mask == '0) |-> q_push.item.pattern_done)
      else $error("empty record pushed without pattern end");

endmodule

`default_nettype wire

>>> hw/rtl/ppu_queue.sv
`default_nettype none

module ppu_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ppu_pkg::q_push_type      q_push,
   input  wire logic                     pop,
   output ppu_pkg::q_status_type         q_status,
   output ppu_pkg::rsp_payload_type      head
);
   import ppu_pkg::*;

   rsp_payload_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head           = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = q_push.valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(q_push.valid) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         mem_ff[wr_ptr_ff] <= q_push.item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push.valid && q_status.full))
      else $error("push into full result queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_status.empty))
      else $error("pop from empty result queue");

endmodule

`default_nettype wire

>>> hw/rtl/ppu_back.sv
`default_nettype none

module ppu_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ppu_pkg::q_status_type    q_status,
   input  wire ppu_pkg::rsp_payload_type head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output ppu_pkg::rsp_payload_type      rsp_payload
);
   import ppu_pkg::*;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;

   // Refill the output register whenever it is empty or being taken.
   assign pop          = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_payload_ff <= head;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/packed_pattern_unpacker.sv
`default_nettype none

// Channel  | Direction | Handshake           | Carries
// req      | in        | req_valid/req_stall | one byte of the packed pattern, last marker
// rsp      | out       | rsp_valid/rsp_stall | one cell record and/or end-of-pattern report
// csr      | in        | csr_valid/csr_ready | song channel count (6 bits)
//
// One byte is taken every cycle unless req_stall is high; each byte is a single phase
// step of the parser. The accepting edge writes a byte's result into the queue, and the
// output register that drives rsp loads it when that register is empty or being taken.
// req_stall rises only when the four-entry result queue is full.
// Reset is synchronous and active high; it returns the parser to a lead byte at row 0
// and sets the song channel count to 32. csr_ready is always high.

module packed_pattern_unpacker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire ppu_pkg::req_payload_type            req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output ppu_pkg::rsp_payload_type                 rsp_payload,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ppu_pkg::CHAN_CNT_W-1:0]      csr_data
);
   import ppu_pkg::*;

   q_push_type      q_push;
   q_status_type    q_status;
   rsp_payload_type q_head;
   logic            q_pop;
   logic            csr_write;

   // The register write is always taken at once.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Front part: parses each byte as it arrives and pushes at most one
   // transaction's worth of result into the queue per byte.
   ppu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_write   (csr_write),
      .csr_data    (csr_data),
      .q_status    (q_status),
      .q_push      (q_push)
   );

   // Short queue so that a stalled result side does not stop parsing at once.
   ppu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .pop      (q_pop),
      .q_status (q_status),
      .head     (q_head)
   );

   // Back part: output register presenting one result transaction at a time.
   ppu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .head        (q_head),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
